>>> src/mkbs_pkg.sv
// ----------------------------------------------------------------------------
// mkbs_pkg
// Shared types and constants for the masked key binary search router.
// ----------------------------------------------------------------------------
package mkbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ENTRIES_W   = 9;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES_IN_USE = 3'd0,
        CFG_OUT_BASE_KEY   = 3'd1,
        CFG_FORWARD_ENABLE = 3'd2,
        CFG_COUNT_ENABLE   = 3'd3,
        CFG_NEURON_LIMIT   = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SPIKE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_SENT      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_RESOLVE
    } state_t;

    typedef struct packed {
        logic [0:0]        op;
        logic [7:0]        entry_index;
        logic [DATA_W-1:0] entry_key;
        logic [DATA_W-1:0] entry_mask;
        logic [DATA_W-1:0] entry_offset;
        logic [DATA_W-1:0] spike_key;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] packet_key;
        logic [DATA_W-1:0] spike_total;
    } out_t;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] offset;
    } entry_t;

endpackage

>>> src/masked_key_binary_search_router.sv
// ----------------------------------------------------------------------------
// masked_key_binary_search_router
// Routes spike keys through a sorted key/mask/offset table by binary search.
// ----------------------------------------------------------------------------
//  channel   signals                          handshake
//  input     start, busy, item                accepted when start && !busy
//  result    result_valid, result             one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data      written when cfg_we
//
//  Table writes leave busy low.
//  A spike takes P probes (P <= 9 at 256 entries) through the single table
//  read port, one probe per read/compare pair.
//  Ignored spikes report in the next cycle, busy low.
//  Reset is asynchronous; table contents are undefined until written.
//  Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module masked_key_binary_search_router (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mkbs_pkg::in_t                    item,
    input  logic                             cfg_we,
    input  logic [mkbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mkbs_pkg::DATA_W-1:0]      cfg_data,
    output logic                             result_valid,
    output mkbs_pkg::out_t                   result
);
    import mkbs_pkg::*;

    entry_t            table_mem [TABLE_DEPTH];
    entry_t            rd_reg;

    state_t            state_reg, state_next;

    logic [ENTRIES_W-1:0] entries_in_use_reg;
    logic [DATA_W-1:0]    out_base_key_reg;
    logic                 forward_enable_reg;
    logic                 count_enable_reg;
    logic [DATA_W-1:0]    neuron_limit_reg;

    logic [DATA_W-1:0] counter_reg, counter_next;
    logic [DATA_W-1:0] spike_reg, spike_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [DATA_W-1:0] id_reg, id_next;

    logic              valid_reg, valid_next;
    out_t              out_reg, out_next;

    logic              accept;
    logic              mem_we;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic              hit;
    logic              go_right;
    logic [CNT_W-1:0]  hi_init;

    assign accept   = start && (state_reg == S_IDLE);
    assign mem_we   = accept && (item.op == OP_WRITE);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CNT_W:1];
    assign hit      = ((spike_reg & rd_reg.mask) == rd_reg.key);
    assign go_right = (rd_reg.key < spike_reg);
    assign hi_init  = (entries_in_use_reg > ENTRIES_W'(TABLE_DEPTH))
                      ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_in_use_reg);

    // table storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[item.entry_index[IDX_W-1:0]] <=
                '{key: item.entry_key, mask: item.entry_mask, offset: item.entry_offset};
        end
        if (state_reg == S_PROBE)
        begin
            rd_reg <= table_mem[mid[IDX_W-1:0]];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
            out_base_key_reg   <= '0;
            forward_enable_reg <= 1'b0;
            count_enable_reg   <= 1'b0;
            neuron_limit_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENTRIES_IN_USE: entries_in_use_reg <= cfg_data[ENTRIES_W-1:0];
                CFG_OUT_BASE_KEY:   out_base_key_reg   <= cfg_data;
                CFG_FORWARD_ENABLE: forward_enable_reg <= cfg_data[0];
                CFG_COUNT_ENABLE:   count_enable_reg   <= cfg_data[0];
                CFG_NEURON_LIMIT:   neuron_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.op == OP_SPIKE) && forward_enable_reg)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = (lo_reg < hi_reg) ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                state_next = hit ? S_RESOLVE : S_PROBE;
            end
            S_RESOLVE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        counter_next = counter_reg;
        spike_next   = spike_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        id_next      = id_reg;
        valid_next   = 1'b0;
        out_next     = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.op == OP_SPIKE))
                begin
                    if (!forward_enable_reg)
                    begin
                        valid_next = 1'b1;
                        out_next   = '{status: ST_IGNORED, packet_key: '0,
                                       spike_total: counter_reg};
                    end
                    else
                    begin
                        if (count_enable_reg)
                        begin
                            counter_next = counter_reg + 1'b1;
                        end
                        spike_next = item.spike_key;
                        lo_next    = '0;
                        hi_next    = hi_init;
                    end
                end
            end
            S_PROBE:
            begin
                mid_next = mid;
                if (!(lo_reg < hi_reg))
                begin
                    valid_next = 1'b1;
                    out_next   = '{status: ST_NOT_FOUND, packet_key: '0,
                                   spike_total: counter_reg};
                end
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    id_next = rd_reg.offset + (spike_reg & ~rd_reg.mask);
                end
                else if (go_right)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            S_RESOLVE:
            begin
                valid_next = 1'b1;
                if (id_reg >= neuron_limit_reg)
                begin
                    out_next = '{status: ST_RANGE, packet_key: '0,
                                 spike_total: counter_reg};
                end
                else
                begin
                    out_next = '{status: ST_SENT, packet_key: out_base_key_reg | id_reg,
                                 spike_total: counter_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            counter_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spike_reg <= spike_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        id_reg    <= id_next;
        out_reg   <= out_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result       = out_reg;

endmodule

>>> src/mkbs_checker.sv
// ----------------------------------------------------------------------------
// mkbs_checker
// Port-level checks for the masked key binary search router.
// ----------------------------------------------------------------------------
module mkbs_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  mkbs_pkg::in_t   item,
    input  logic            result_valid,
    input  mkbs_pkg::out_t  result
);
    import mkbs_pkg::*;

    // table write transaction gives no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == OP_WRITE)) |=> !result_valid)
        else $error("result after table write");

    // spike transaction either reports at once or starts a search
    a_spike_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == OP_SPIKE)) |=> (result_valid || busy))
        else $error("spike dropped");

    // every search ends with a result
    a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("search ended without result");

    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while busy");

    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_SENT)) |-> (result.packet_key == '0))
        else $error("packet key set on unsent result");

endmodule

bind masked_key_binary_search_router mkbs_checker u_mkbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);

>>> test/tb_masked_key_binary_search_router.sv
// ----------------------------------------------------------------------------
// tb_masked_key_binary_search_router
// Self-checking testbench for the masked key binary search router. A local
// model of the routing table, counter and registers predicts each spike
// result. The checker compares every strobed result field by field against
// the oldest prediction. Directed tests cover the reset state, an empty
// table, hand-built tables, id wrap and limits, and a full 256-entry table
// with oversized entry counts. Random rounds then load sorted tables and
// route mostly matching spikes. The sender idles at three different rates.
// ----------------------------------------------------------------------------
module tb_masked_key_binary_search_router;
    import mkbs_pkg::*;

    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 145;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_t                  item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 result_valid;
    out_t                 result;

    masked_key_binary_search_router u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    entry_t               route_table [TABLE_DEPTH];
    bit                   slot_written [TABLE_DEPTH];
    int                   loaded_prefix = 0;
    logic [ENTRIES_W-1:0] active_entries = '0;
    logic [DATA_W-1:0]    base_key = '0;
    logic [DATA_W-1:0]    id_limit = '0;
    logic [DATA_W-1:0]    model_total = '0;
    logic                 fwd_on = 1'b0;
    logic                 count_on = 1'b0;

    out_t expected_routes [$];
    int   idle_pct = 27;
    int   errors = 0;
    int   quiet_cycles = 0;
    int   n_writes = 0;
    int   n_spikes = 0;
    int   n_checked = 0;
    int   status_seen [4] = '{0, 0, 0, 0};

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic out_t route_spike(input logic [DATA_W-1:0] sk);
        out_t          r;
        int            lo;
        int            hi;
        int            mid;
        entry_t        e;
        logic [31:0]   id;
        bit            found;
        r.status     = ST_NOT_FOUND;
        r.packet_key = '0;
        if (!fwd_on) begin
            r.status      = ST_IGNORED;
            r.spike_total = model_total;
            return r;
        end
        if (count_on)
            model_total = model_total + 32'd1;
        lo    = 0;
        hi    = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_entries);
        found = 0;
        while (!found && lo < hi) begin
            mid = (lo + hi) >> 1;
            e   = route_table[mid];
            if ((sk & e.mask) == e.key) begin
                found = 1;
                id    = e.offset + (sk & ~e.mask);
                if (id >= id_limit)
                    r.status = ST_RANGE;
                else
                begin
                    r.status     = ST_SENT;
                    r.packet_key = base_key | id;
                end
            end
            else if (e.key < sk)
                lo = mid + 1;
            else
                hi = mid;
        end
        r.spike_total = model_total;
        return r;
    endfunction

    function automatic in_t make_write(input logic [7:0] idx, input logic [31:0] k,
                                       input logic [31:0] m, input logic [31:0] o);
        in_t it;
        it.op           = OP_WRITE;
        it.entry_index  = idx;
        it.entry_key    = k;
        it.entry_mask   = m;
        it.entry_offset = o;
        it.spike_key    = $urandom();
        return it;
    endfunction

    function automatic in_t make_spike(input logic [31:0] sk);
        in_t it;
        it.op           = OP_SPIKE;
        it.entry_index  = 8'($urandom());
        it.entry_key    = $urandom();
        it.entry_mask   = $urandom();
        it.entry_offset = $urandom();
        it.spike_key    = sk;
        return it;
    endfunction

    // Mostly keys inside a live entry's block, some just outside it.
    function automatic logic [31:0] pick_spike();
        int     eff;
        int     r;
        entry_t e;
        eff = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_entries);
        if (eff == 0)
            return $urandom();
        e = route_table[$urandom_range(0, eff - 1)];
        r = $urandom_range(0, 99);
        if (r < 70)
            return e.key | ($urandom() & ~e.mask);
        else if (r < 80)
            return e.key - 1;
        else if (r < 90)
            return (e.key | ~e.mask) + 1;
        return $urandom();
    endfunction

    // Leaves start high on return so the next transaction can follow back to back.
    task automatic send_item(input in_t it);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (it.op == OP_WRITE) begin
            route_table[it.entry_index]  = '{it.entry_key, it.entry_mask, it.entry_offset};
            slot_written[it.entry_index] = 1'b1;
            while (loaded_prefix < TABLE_DEPTH && slot_written[loaded_prefix])
                loaded_prefix++;
            n_writes++;
        end
        else
        begin
            expected_routes.push_back(route_spike(it.spike_key));
            n_spikes++;
        end
    endtask

    task automatic drain_routes();
        start <= 1'b0;
        while (expected_routes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            CFG_ENTRIES_IN_USE: active_entries = d[ENTRIES_W-1:0];
            CFG_OUT_BASE_KEY:   base_key       = d;
            CFG_FORWARD_ENABLE: fwd_on         = d[0];
            CFG_COUNT_ENABLE:   count_on       = d[0];
            CFG_NEURON_LIMIT:   id_limit       = d;
            default: ;
        endcase
    endtask

    // Unused upper data bits carry junk half of the time.
    task automatic write_regs(input logic [8:0] n, input logic [31:0] base, input logic fwd,
                              input logic cnt, input logic [31:0] lim);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom();
        cfg_write(CFG_ENTRIES_IN_USE, (junk & ~32'h1FF) | 32'(n));
        cfg_write(CFG_OUT_BASE_KEY, base);
        cfg_write(CFG_FORWARD_ENABLE, (junk & ~32'h1) | 32'(fwd));
        cfg_write(CFG_COUNT_ENABLE, (junk & ~32'h1) | 32'(cnt));
        cfg_write(CFG_NEURON_LIMIT, lim);
        cfg_we <= 1'b0;
    endtask

    // Sorted, non-overlapping aligned blocks in slots 0..n-1.
    task automatic build_table(input int n);
        logic [63:0] cursor;
        logic [63:0] blk;
        logic [31:0] off;
        int          w;
        cursor = ($urandom_range(0, 3) == 0) ? 64'd0 : ({32'd0, $urandom()} & 64'hFF7F_FFFF);
        for (int i = 0; i < n; i++) begin
            w      = $urandom_range(0, 8);
            blk    = 64'd1 << w;
            cursor = (cursor + blk - 1) & ~(blk - 1);
            off    = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4095);
            send_item(make_write(8'(i), cursor[31:0], 32'hFFFF_FFFF << w, off));
            cursor = cursor + blk + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4095));
        end
    endtask

    task automatic run_round(input int n);
        int          entries;
        logic [31:0] lim;
        build_table(n);
        drain_routes();
        entries = n;
        case ($urandom_range(0, 9))
            0: entries = $urandom_range(0, n);
            1: if (loaded_prefix == TABLE_DEPTH) entries = $urandom_range(n, 511);
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0:       lim = 32'd0;
            1:       lim = 32'hFFFF_FFFF;
            2:       lim = $urandom_range(1, 8192);
            3:       lim = $urandom();
            default: lim = $urandom_range(2048, 65535);
        endcase
        write_regs(9'(entries), $urandom(), $urandom_range(0, 9) != 0,
                   1'($urandom_range(0, 1)), lim);
        repeat ($urandom_range(12, 36)) begin
            if ($urandom_range(0, 99) < 10)
                send_item(make_write(8'($urandom_range(0, 255)), $urandom(), $urandom(),
                                     $urandom()));
            else
                send_item(make_spike(pick_spike()));
            if ($urandom_range(0, 99) < 4)
                drain_routes();
        end
    endtask

    task automatic test_reset_state();
        send_item(make_spike(32'h0000_0000));
        drain_routes();
        // counting on but forwarding off: counter must hold
        write_regs(9'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_item(make_spike(32'hFFFF_FFFF));
    endtask

    task automatic test_empty_table();
        drain_routes();
        write_regs(9'd0, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(make_spike(32'h0000_0000));
        send_item(make_spike(32'hFFFF_FFFF));
    endtask

    task automatic test_small_table();
        logic [31:0] keys [9] = '{32'h0000_00FF, 32'h0000_100F, 32'h0001_0000,
                                  32'h8000_0010, 32'h8FFF_FFFF, 32'hFFFF_FFFF,
                                  32'h0000_0100, 32'h0000_2000, 32'hFFFF_FFFE};
        send_item(make_write(8'd0, 32'h0000_0000, 32'hFFFF_FF00, 32'h0000_0000));
        send_item(make_write(8'd1, 32'h0000_1000, 32'hFFFF_FFF0, 32'h0000_0100));
        send_item(make_write(8'd2, 32'h0001_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        // offset near the top: id wraps around
        send_item(make_write(8'd3, 32'h8000_0000, 32'hF000_0000, 32'hFFFF_FFF0));
        send_item(make_write(8'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_write(8'd255, $urandom(), $urandom(), $urandom()));
        drain_routes();
        write_regs(9'd5, 32'hA5A5_0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
        foreach (keys[i])
            send_item(make_spike(keys[i]));
    endtask

    task automatic test_limits();
        drain_routes();
        write_regs(9'd5, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0100);
        send_item(make_spike(32'h0000_00FF));
        send_item(make_spike(32'h0000_1000));
        drain_routes();
        write_regs(9'd5, 32'h0, 1'b1, 1'b1, 32'h0);
        send_item(make_spike(32'h0000_00FF));
        drain_routes();
        write_regs(9'd1, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(make_spike(32'h0000_100F));
        send_item(make_spike(32'h0000_00FF));
    endtask

    task automatic test_full_table();
        int sizes [3] = '{256, 511, 257};
        build_table(TABLE_DEPTH);
        foreach (sizes[i]) begin
            drain_routes();
            write_regs(9'(sizes[i]), $urandom(), 1'b1, 1'b1, 32'hFFFF_FFFF);
            repeat (12) send_item(make_spike(pick_spike()));
        end
    endtask

    task automatic test_random_traffic(input int pct);
        int first;
        idle_pct = pct;
        first    = n_writes + n_spikes;
        while (n_writes + n_spikes - first < PHASE_ITEMS)
            run_round(($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 16));
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Results are stable over their strobe cycle; sample mid-cycle.
    always @(negedge clk) begin
        out_t exp_r;
        if (rst_n && result_valid) begin
            if (expected_routes.size() == 0) begin
                $error("result with no transaction pending: status %0d key 0x%08h",
                       result.status, result.packet_key);
                errors++;
            end
            else
            begin
                exp_r = expected_routes.pop_front();
                status_seen[int'(exp_r.status)]++;
                compare_field("status", 32'(exp_r.status), 32'(result.status));
                compare_field("packet_key", exp_r.packet_key, result.packet_key);
                compare_field("spike_total", exp_r.spike_total, result.spike_total);
                n_checked++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid || cfg_we)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ENTRIES_IN_USE;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_empty_table();
        test_small_table();
        test_limits();
        test_full_table();
        test_random_traffic(27);
        test_random_traffic(66);
        test_random_traffic(0);
        drain_routes();

        $display("Run covered %0d table writes and %0d spikes; %0d results checked.",
                 n_writes, n_spikes, n_checked);
        $display("Outcomes: %0d sent, %0d not found, %0d out of range, %0d ignored.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
